// ===== sv/ltr_pkg.sv =====
// ----------------------------------------------------------------------------
// ltr_pkg: shared constants
// Field widths, command codes, register indexes and scratch bank codes for
// the linear recurrence n-th term core.
// ----------------------------------------------------------------------------
`default_nettype none

package ltr_pkg;

  localparam int unsigned DW      = 31;  // value width
  localparam int unsigned NW      = 63;  // term index width
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned EIDX_W  = 4;
  localparam int unsigned ORD_W   = 5;
  localparam int unsigned CFG_AW  = 1;
  localparam int unsigned TOP_BIT = 62;

  localparam logic [CMD_W-1:0] CMD_WR_COEF = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_INIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_AW-1:0] REG_MODULUS = 1'd0;
  localparam logic [CFG_AW-1:0] REG_ORDER   = 1'd1;

  localparam logic [DW-1:0]    MODULUS_RESET = 31'd1000000007;
  localparam logic [ORD_W-1:0] ORDER_RESET   = 5'd1;

  // scratch memory banks
  localparam logic [2:0] BANK_RAWC = 3'd0;
  localparam logic [2:0] BANK_RAWA = 3'd1;
  localparam logic [2:0] BANK_RC   = 3'd2;
  localparam logic [2:0] BANK_RA   = 3'd3;
  localparam logic [2:0] BANK_W    = 3'd4;
  localparam logic [2:0] BANK_S    = 3'd5;
  localparam logic [2:0] BANK_P    = 3'd6;
  localparam logic [2:0] BANK_MISC = 3'd7;

  // slots in the misc bank
  localparam int unsigned MISC_ZERO = 0;
  localparam int unsigned MISC_ONE  = 1;
  localparam int unsigned MISC_TOP  = 2;
  localparam int unsigned MISC_ACC  = 3;

endpackage

`default_nettype wire

// ===== sv/ltr_ram.sv =====
// ----------------------------------------------------------------------------
// ltr_ram: scratch memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ltr_ram #(
  parameter int unsigned AW = 7,
  parameter int unsigned DW = 31
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ltr_modmul.sv =====
// ----------------------------------------------------------------------------
// ltr_modmul: serial modular multiply-add
// Computes (a * b + c) mod m, one bit of a per cycle; b and c below m.
// ----------------------------------------------------------------------------
`default_nettype none

module ltr_modmul (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [ltr_pkg::DW-1:0] a_i,
  input  wire logic [ltr_pkg::DW-1:0] b_i,
  input  wire logic [ltr_pkg::DW-1:0] c_i,
  input  wire logic [ltr_pkg::DW-1:0] m_i,
  output logic                        done_o,
  output logic      [ltr_pkg::DW-1:0] res_o
);

  localparam int unsigned DW = ltr_pkg::DW;
  localparam int unsigned CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy_q, fin_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] a_q, b_q, c_q, r_q;
  logic [DW:0]   dbl, dbl_r, add, add_r, fsum, fsum_r;

  always_comb begin
    dbl    = {r_q, 1'b0};
    dbl_r  = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    add    = dbl_r + {1'b0, b_q};
    add_r  = (add >= {1'b0, m_i}) ? add - {1'b0, m_i} : add;
    fsum   = {1'b0, r_q} + {1'b0, c_q};
    fsum_r = (fsum >= {1'b0, m_i}) ? fsum - {1'b0, m_i} : fsum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (fin_q) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b0;
          done_q <= 1'b1;
        end else if (cnt_q == LAST) begin
          fin_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      c_q <= c_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (fin_q) begin
        r_q <= fsum_r[DW-1:0];
      end else begin
        // msb first: r = 2r + bit*b
        r_q <= a_q[DW-1] ? add_r[DW-1:0] : dbl_r[DW-1:0];
        a_q <= {a_q[DW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

`default_nettype wire

// ===== sv/linear_recurrence_nth_term_mod_core.sv =====
// load beats are accepted only while no compute runs
// multiply-add jobs that a compute beat runs on the serial unit:
//   jobs = 3k + B*(2k*k + 3k) + S*(k+1), k = order, B = bits of n below and
//   including its top set bit, S = set bits
// one item at a time; the serial multiply-add and the single read port set it
// reset clears both tables through valid bits, modulus 1000000007, order 1
`default_nettype none

module linear_recurrence_nth_term_mod_core #(
  parameter int unsigned MAX_ORDER = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, entry_value, term_index (from bit 0)
  input  wire logic [103:0]               s_axis_tdata,
  // cmd
  input  wire logic [1:0]                 s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // term_value
  output logic      [31:0]                m_axis_tdata,
  input  wire logic                       cfg_we_i,
  input  wire logic [ltr_pkg::CFG_AW-1:0] cfg_addr_i,
  input  wire logic [ltr_pkg::DW-1:0]     cfg_wdata_i
);

  localparam int unsigned DW  = ltr_pkg::DW;
  localparam int unsigned NW  = ltr_pkg::NW;
  localparam int unsigned IW  = (MAX_ORDER > 4) ? $clog2(MAX_ORDER) : 2;
  localparam int unsigned KW  = IW + 1;
  localparam int unsigned AW  = IW + 3;
  localparam int unsigned DEP = 2 ** IW;

  localparam logic [3:0] P_IDLE  = 4'd0;
  localparam logic [3:0] P_CONST = 4'd1;
  localparam logic [3:0] P_WINIT = 4'd2;
  localparam logic [3:0] P_RED   = 4'd3;
  localparam logic [3:0] P_SCAN  = 4'd4;
  localparam logic [3:0] P_DCOPY = 4'd5;
  localparam logic [3:0] P_DMAC  = 4'd6;
  localparam logic [3:0] P_STOP  = 4'd7;
  localparam logic [3:0] P_SLOOP = 4'd8;
  localparam logic [3:0] P_DWB   = 4'd9;
  localparam logic [3:0] P_SUM   = 4'd10;
  localparam logic [3:0] P_OUT   = 4'd11;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_RB   = 3'd1;
  localparam logic [2:0] E_RC   = 3'd2;
  localparam logic [2:0] E_GO   = 3'd3;
  localparam logic [2:0] E_MUL  = 3'd4;

  localparam logic [IW-1:0] I_ZERO = IW'(ltr_pkg::MISC_ZERO);
  localparam logic [IW-1:0] I_ONE  = IW'(ltr_pkg::MISC_ONE);
  localparam logic [IW-1:0] I_TOP  = IW'(ltr_pkg::MISC_TOP);
  localparam logic [IW-1:0] I_ACC  = IW'(ltr_pkg::MISC_ACC);

  function automatic logic [AW-1:0] mk(input logic [2:0] bank, input logic [IW-1:0] idx);
    return {bank, idx};
  endfunction

  // input beat fields
  logic [ltr_pkg::CMD_W-1:0]  in_cmd;
  logic [ltr_pkg::EIDX_W-1:0] in_idx;
  logic [DW-1:0]              in_val;
  logic [NW-1:0]              in_n;
  logic                       in_acc;

  assign in_cmd = s_axis_tuser;
  assign in_idx = s_axis_tdata[3:0];
  assign in_val = s_axis_tdata[34:4];
  assign in_n   = s_axis_tdata[97:35];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic [3:0]              ph_q;
  logic [DW-1:0]           mod_q, m_q;
  logic [ltr_pkg::ORD_W-1:0] ord_q;
  logic                    one_q;
  logic [KW-1:0]           k_q, i_q, j_q;
  logic [NW-1:0]           n_q;
  logic [6:0]              bits_q;
  logic                    vsel_q;       // step target: 0 shifted, 1 working
  logic                    issued_q;
  logic [DEP-1:0]          vc_q, va_q;
  logic                    rv_q;
  logic [DW-1:0]           res_q;
  logic                    ov_q;
  logic [DW-1:0]           od_q;

  logic [2:0]    e_st_q;
  logic [AW-1:0] eb_q, ec_q, ed_q;
  logic [DW-1:0] opa_q, opb_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata, rd_m;

  logic          mm_start, mm_done;
  logic [DW-1:0] mm_res;

  logic          job_go;
  logic [AW-1:0] ja, jb, jc, jd;
  logic [IW-1:0] ii, jj, jm1, km1;
  logic [2:0]    vbank;
  logic          i_last, j_last, is_load, idx_ok;
  logic [KW-1:0] k_new;

  assign ii    = i_q[IW-1:0];
  assign jj    = j_q[IW-1:0];
  assign jm1   = jj - IW'(1);
  assign km1   = IW'(k_q - KW'(1));
  assign vbank = vsel_q ? ltr_pkg::BANK_W : ltr_pkg::BANK_S;
  assign i_last = (i_q == k_q - KW'(1));
  assign j_last = (j_q == k_q - KW'(1));

  assign is_load = (in_cmd == ltr_pkg::CMD_WR_COEF) || (in_cmd == ltr_pkg::CMD_WR_INIT);
  assign idx_ok  = (32'(in_idx) < MAX_ORDER);

  always_comb begin
    if (ord_q == '0) begin
      k_new = KW'(1);
    end else if (32'(ord_q) > MAX_ORDER) begin
      k_new = KW'(MAX_ORDER);
    end else begin
      k_new = KW'(ord_q);
    end
  end

  assign s_axis_tready = (ph_q == P_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, od_q};

  // job generator
  always_comb begin
    ja = '0;
    jb = mk(ltr_pkg::BANK_MISC, I_ONE);
    jc = mk(ltr_pkg::BANK_MISC, I_ZERO);
    jd = '0;
    job_go = 1'b0;
    unique case (ph_q)
      P_RED: begin
        job_go = 1'b1;
        ja = mk(j_q[0] ? ltr_pkg::BANK_RAWA : ltr_pkg::BANK_RAWC, ii);
        jd = mk(j_q[0] ? ltr_pkg::BANK_RA : ltr_pkg::BANK_RC, ii);
      end
      P_DCOPY: begin
        job_go = 1'b1;
        ja = mk(ltr_pkg::BANK_W, ii);
        jd = mk(ltr_pkg::BANK_S, ii);
      end
      P_DMAC: begin
        job_go = 1'b1;
        ja = mk(ltr_pkg::BANK_S, jj);
        jb = mk(ltr_pkg::BANK_W, ii);
        if (i_q != '0) begin
          jc = mk(ltr_pkg::BANK_P, jj);
        end
        jd = mk(ltr_pkg::BANK_P, jj);
      end
      P_STOP: begin
        job_go = 1'b1;
        ja = mk(vbank, km1);
        jd = mk(ltr_pkg::BANK_MISC, I_TOP);
      end
      P_SLOOP: begin
        // new v[t] = c[t]*top + old v[t-1], walked downward
        job_go = 1'b1;
        ja = mk(ltr_pkg::BANK_RC, jj);
        jb = mk(ltr_pkg::BANK_MISC, I_TOP);
        if (j_q != '0) begin
          jc = mk(vbank, jm1);
        end
        jd = mk(vbank, jj);
      end
      P_DWB: begin
        job_go = 1'b1;
        ja = mk(ltr_pkg::BANK_P, ii);
        jd = mk(ltr_pkg::BANK_W, ii);
      end
      P_SUM: begin
        job_go = 1'b1;
        ja = mk(ltr_pkg::BANK_W, ii);
        jb = mk(ltr_pkg::BANK_RA, ii);
        if (i_q != '0) begin
          jc = mk(ltr_pkg::BANK_MISC, I_ACC);
        end
        jd = mk(ltr_pkg::BANK_MISC, I_ACC);
      end
      default: job_go = 1'b0;
    endcase
    job_go = job_go && !issued_q && (e_st_q == E_IDLE);
  end

  // memory port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    priority if (mm_done) begin
      ram_we    = 1'b1;
      ram_waddr = ed_q;
      ram_wdata = mm_res;
    end else if (ph_q == P_CONST) begin
      ram_we    = 1'b1;
      ram_waddr = mk(ltr_pkg::BANK_MISC, (i_q == '0) ? I_ZERO : I_ONE);
      ram_wdata = (i_q == '0) ? '0 : DW'(one_q);
    end else if (ph_q == P_WINIT) begin
      ram_we    = 1'b1;
      ram_waddr = mk(ltr_pkg::BANK_W, ii);
      ram_wdata = (i_q == '0) ? DW'(one_q) : '0;
    end else if (in_acc && is_load && idx_ok) begin
      ram_we    = 1'b1;
      ram_waddr = mk((in_cmd == ltr_pkg::CMD_WR_COEF) ? ltr_pkg::BANK_RAWC
                                                      : ltr_pkg::BANK_RAWA, IW'(in_idx));
      ram_wdata = in_val;
    end
  end

  always_comb begin
    unique case (e_st_q)
      E_IDLE:  ram_raddr = ja;
      E_RB:    ram_raddr = eb_q;
      E_RC:    ram_raddr = ec_q;
      default: ram_raddr = '0;
    endcase
  end

  // raw table entries never written read as zero
  assign rd_m     = rv_q ? ram_rdata : '0;
  assign mm_start = (e_st_q == E_GO);

  ltr_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ltr_modmul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (opa_q),
    .b_i     (opb_q),
    .c_i     (rd_m),
    .m_i     (m_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  // job engine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_st_q <= E_IDLE;
      rv_q   <= 1'b0;
    end else begin
      unique case (ram_raddr[AW-1:IW])
        ltr_pkg::BANK_RAWC: rv_q <= vc_q[ram_raddr[IW-1:0]];
        ltr_pkg::BANK_RAWA: rv_q <= va_q[ram_raddr[IW-1:0]];
        default:            rv_q <= 1'b1;
      endcase
      unique case (e_st_q)
        E_IDLE:  if (job_go) e_st_q <= E_RB;
        E_RB:    e_st_q <= E_RC;
        E_RC:    e_st_q <= E_GO;
        E_GO:    e_st_q <= E_MUL;
        E_MUL:   if (mm_done) e_st_q <= E_IDLE;
        default: e_st_q <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_go) begin
      eb_q <= jb;
      ec_q <= jc;
      ed_q <= jd;
    end
    if (e_st_q == E_RB) opa_q <= rd_m;
    if (e_st_q == E_RC) opb_q <= rd_m;
    if (mm_done) res_q <= mm_res;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= P_IDLE;
      mod_q    <= ltr_pkg::MODULUS_RESET;
      ord_q    <= ltr_pkg::ORDER_RESET;
      m_q      <= ltr_pkg::MODULUS_RESET;
      one_q    <= 1'b1;
      k_q      <= KW'(1);
      i_q      <= '0;
      j_q      <= '0;
      n_q      <= '0;
      bits_q   <= '0;
      vsel_q   <= 1'b0;
      issued_q <= 1'b0;
      vc_q     <= '0;
      va_q     <= '0;
      ov_q     <= 1'b0;
      od_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          ltr_pkg::REG_MODULUS: mod_q <= cfg_wdata_i;
          ltr_pkg::REG_ORDER:   ord_q <= cfg_wdata_i[ltr_pkg::ORD_W-1:0];
          default: ;
        endcase
      end
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      if (job_go) issued_q <= 1'b1;
      if (mm_done) issued_q <= 1'b0;

      unique case (ph_q)
        P_IDLE: begin
          if (in_acc && is_load && idx_ok) begin
            if (in_cmd == ltr_pkg::CMD_WR_COEF) vc_q[IW'(in_idx)] <= 1'b1;
            else                                va_q[IW'(in_idx)] <= 1'b1;
          end
          if (in_acc && (in_cmd == ltr_pkg::CMD_COMPUTE)) begin
            m_q    <= (mod_q == '0) ? DW'(1) : mod_q;
            one_q  <= (mod_q > DW'(1));
            k_q    <= k_new;
            n_q    <= in_n;
            bits_q <= 7'(NW);
            i_q    <= '0;
            ph_q   <= P_CONST;
          end
        end
        P_CONST: begin
          if (i_q == '0) begin
            i_q <= KW'(1);
          end else begin
            i_q  <= '0;
            ph_q <= P_WINIT;
          end
        end
        P_WINIT: begin
          if (i_last) begin
            i_q  <= '0;
            j_q  <= '0;
            ph_q <= P_RED;
          end else begin
            i_q <= i_q + KW'(1);
          end
        end
        P_RED: if (mm_done) begin
          if (j_q == '0) begin
            j_q <= KW'(1);
          end else begin
            j_q <= '0;
            i_q <= i_q + KW'(1);
            if (i_last) ph_q <= P_SCAN;
          end
        end
        P_SCAN: begin
          // skip leading zeros of n
          i_q <= '0;
          if (n_q == '0) begin
            ph_q <= P_SUM;
          end else if (n_q[ltr_pkg::TOP_BIT]) begin
            ph_q <= P_DCOPY;
          end else begin
            n_q    <= {n_q[NW-2:0], 1'b0};
            bits_q <= bits_q - 7'd1;
          end
        end
        P_DCOPY: if (mm_done) begin
          i_q <= i_q + KW'(1);
          if (i_last) begin
            i_q  <= '0;
            j_q  <= '0;
            ph_q <= P_DMAC;
          end
        end
        P_DMAC: if (mm_done) begin
          j_q <= j_q + KW'(1);
          if (j_last) begin
            vsel_q <= 1'b0;
            ph_q   <= P_STOP;
          end
        end
        P_STOP: if (mm_done) begin
          j_q  <= k_q - KW'(1);
          ph_q <= P_SLOOP;
        end
        P_SLOOP: if (mm_done) begin
          j_q <= j_q - KW'(1);
          if (j_q == '0) begin
            if (!vsel_q) begin
              j_q <= '0;
              i_q <= i_q + KW'(1);
              if (i_last) begin
                i_q  <= '0;
                ph_q <= P_DWB;
              end else begin
                ph_q <= P_DMAC;
              end
            end else begin
              // next bit of n
              i_q    <= '0;
              n_q    <= {n_q[NW-2:0], 1'b0};
              bits_q <= bits_q - 7'd1;
              ph_q   <= (bits_q == 7'd1) ? P_SUM : P_DCOPY;
            end
          end
        end
        P_DWB: if (mm_done) begin
          i_q <= i_q + KW'(1);
          if (i_last) begin
            i_q <= '0;
            if (n_q[ltr_pkg::TOP_BIT]) begin
              vsel_q <= 1'b1;
              ph_q   <= P_STOP;
            end else begin
              n_q    <= {n_q[NW-2:0], 1'b0};
              bits_q <= bits_q - 7'd1;
              ph_q   <= (bits_q == 7'd1) ? P_SUM : P_DCOPY;
            end
          end
        end
        P_SUM: if (mm_done) begin
          i_q <= i_q + KW'(1);
          if (i_last) ph_q <= P_OUT;
        end
        P_OUT: begin
          if (!ov_q || m_axis_tready) begin
            ov_q <= 1'b1;
            od_q <= res_q;
            ph_q <= P_IDLE;
          end
        end
        default: ph_q <= P_IDLE;
      endcase
    end
  end

  // raw tables are only written between computes
  a_raw_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ((ram_waddr[AW-1:IW] == ltr_pkg::BANK_RAWC) ||
                (ram_waddr[AW-1:IW] == ltr_pkg::BANK_RAWA))) |-> (ph_q == P_IDLE))
    else $error("raw table written during compute");

  a_idle_engine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == P_IDLE) |-> (e_st_q == E_IDLE) && !issued_q)
    else $error("job engine busy while idle");

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> issued_q && (e_st_q == E_MUL))
    else $error("multiply result without a job");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == P_OUT) && ov_q && !m_axis_tready |=> (ph_q == P_OUT))
    else $error("result overwrote waiting beat");

endmodule

`default_nettype wire

// ===== bench/linear_recurrence_nth_term_mod_core_test.sv =====
// ----------------------------------------------------------------------------
// linear_recurrence_nth_term_mod_core_test: self-checking bench
// Drives load, compute and unused beats into the core, takes each term from a
// directed row or a local Kitamasa model, checks every result beat in order,
// with bursty input, a stalling output and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module linear_recurrence_nth_term_mod_core_test;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned LIMIT     = 8_000_000;
  localparam logic [1:0]  CMD_SPARE = 2'd3;

  typedef longint unsigned vec_t [DEPTH];

  typedef struct packed {
    logic [ltr_pkg::CMD_W-1:0]  cmd;
    logic [ltr_pkg::EIDX_W-1:0] idx;
    logic [ltr_pkg::DW-1:0]     val;
    logic [ltr_pkg::NW-1:0]     n;
    logic                       fixed;
    logic [ltr_pkg::DW-1:0]     term;
  } row_t;

  localparam int NUM_ROWS = 12;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ltr_pkg::CMD_COMPUTE, 4'd0,  31'd0,          63'd0,  1'b1, 31'd0},
    '{CMD_SPARE,            4'd0,  31'd5,          63'd0,  1'b0, 31'd0},
    '{ltr_pkg::CMD_WR_INIT, 4'd0,  31'd7,          63'd0,  1'b0, 31'd0},
    '{ltr_pkg::CMD_COMPUTE, 4'd0,  31'd0,          63'd0,  1'b1, 31'd7},
    '{ltr_pkg::CMD_WR_COEF, 4'd0,  31'd2,          63'd0,  1'b0, 31'd0},
    '{ltr_pkg::CMD_COMPUTE, 4'd0,  31'd0,          63'd1,  1'b1, 31'd14},
    '{ltr_pkg::CMD_COMPUTE, 4'd0,  31'd0,          63'd10, 1'b1, 31'd7168},
    '{ltr_pkg::CMD_COMPUTE, 4'hf,  31'h7fffffff,   {63{1'b1}}, 1'b0, 31'd0},
    '{ltr_pkg::CMD_WR_COEF, 4'd0,  31'h7fffffff,   63'd0,  1'b0, 31'd0},
    '{ltr_pkg::CMD_WR_INIT, 4'hf,  31'h7fffffff,   63'd0,  1'b0, 31'd0},
    '{ltr_pkg::CMD_COMPUTE, 4'd0,  31'd0,          63'd5,  1'b0, 31'd0},
    '{ltr_pkg::CMD_WR_COEF, 4'hf,  31'd0,          63'd0,  1'b0, 31'd0}
  };

  logic          clk_i, rst_ni;
  logic          s_axis_tvalid, s_axis_tready;
  logic [103:0]  s_axis_tdata;
  logic [1:0]    s_axis_tuser;
  logic          m_axis_tvalid, m_axis_tready;
  logic [31:0]   m_axis_tdata;
  logic          cfg_we_i;
  logic [ltr_pkg::CFG_AW-1:0] cfg_addr_i;
  logic [ltr_pkg::DW-1:0] cfg_wdata_i;

  linear_recurrence_nth_term_mod_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  // model state
  logic [ltr_pkg::DW-1:0]    mod_q;
  logic [ltr_pkg::ORD_W-1:0] order_q;
  logic [ltr_pkg::DW-1:0]    coef_tab [DEPTH];
  logic [ltr_pkg::DW-1:0]    init_tab [DEPTH];
  logic [ltr_pkg::DW-1:0]    term_q [$];

  int unsigned err_cnt, cycle_cnt, hold_left;
  bit          hold_req;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic vec_t step_vec(vec_t v, int unsigned k, longint unsigned m);
    longint unsigned top;
    top = v[k-1];
    for (int i = DEPTH - 1; i > 0; i--) begin
      if (i < k) v[i] = v[i-1];
    end
    v[0] = 0;
    for (int i = 0; i < k; i++) begin
      v[i] = (v[i] + (longint'(coef_tab[i]) % m) * top) % m;
    end
    return v;
  endfunction

  function automatic logic [ltr_pkg::DW-1:0] predict_term(logic [ltr_pkg::NW-1:0] n);
    longint unsigned m, acc;
    int unsigned k;
    int b;
    vec_t w, sh, pr;
    m = (mod_q == 0) ? 1 : longint'(mod_q);
    k = (order_q == 0) ? 1 : ((order_q > DEPTH) ? DEPTH : order_q);
    for (int i = 0; i < DEPTH; i++) w[i] = 0;
    w[0] = 1 % m;
    if (n != 0) begin
      b = ltr_pkg::TOP_BIT;
      while (!n[b]) b--;
      for (; b >= 0; b--) begin
        sh = w;
        for (int i = 0; i < DEPTH; i++) pr[i] = 0;
        for (int i = 0; i < k; i++) begin
          for (int j = 0; j < k; j++) pr[j] = (pr[j] + sh[j] * w[i]) % m;
          sh = step_vec(sh, k, m);
        end
        w = pr;
        if (n[b]) w = step_vec(w, k, m);
      end
    end
    acc = 0;
    for (int i = 0; i < k; i++) acc = (acc + w[i] * (longint'(init_tab[i]) % m)) % m;
    return acc[ltr_pkg::DW-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %0d, got %0d at cycle %0d", what, want, got, cycle_cnt);
    err_cnt++;
  endtask

  // result beats are stable by the falling edge and complete at the next rising one
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (term_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, m_axis_tdata);
      end else begin
        if (m_axis_tdata !== {1'b0, term_q[0]})
          report_mismatch("term_value", {1'b0, term_q[0]}, m_axis_tdata);
        void'(term_q.pop_front());
      end
    end
  end

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin
    int unsigned mode, mode_left;
    mode = 0;
    mode_left = 0;
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 120000;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= ($urandom_range(0, 9) == 0);
          default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that accepts the beat
  task automatic send_item(logic [1:0] cmd, logic [3:0] idx, logic [ltr_pkg::DW-1:0] val,
                           logic [ltr_pkg::NW-1:0] n, bit fixed,
                           logic [ltr_pkg::DW-1:0] term);
    bit rdy;
    if (burst_left == 0) begin
      int unsigned gap;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, n, val, idx};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    case (cmd)
      ltr_pkg::CMD_WR_COEF: coef_tab[idx] = val;
      ltr_pkg::CMD_WR_INIT: init_tab[idx] = val;
      ltr_pkg::CMD_COMPUTE: term_q.push_back(fixed ? term : predict_term(n));
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [ltr_pkg::DW-1:0] m, logic [ltr_pkg::ORD_W-1:0] k);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (term_q.size() == 0);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= ltr_pkg::REG_MODULUS;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_addr_i <= ltr_pkg::REG_ORDER;
    cfg_wdata_i <= {26'd0, k};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mod_q = m;
    order_q = k;
  endtask

  function automatic logic [ltr_pkg::NW-1:0] rand_n(int unsigned bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (bits == 0) return '0;
    return r[ltr_pkg::NW-1:0] & ((63'd1 << bits) - 63'd1);
  endfunction

  task automatic random_phase(int unsigned items, int unsigned max_bits, bit full_ok);
    int unsigned pick, k;
    logic [63:0] r;
    k = (order_q == 0) ? 1 : ((order_q > DEPTH) ? DEPTH : order_q);
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 9);
      r = {$urandom, $urandom};
      if (pick < 6) begin
        send_item(($urandom_range(0, 1) == 1) ? ltr_pkg::CMD_WR_COEF : ltr_pkg::CMD_WR_INIT,
                  ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, k - 1)) : 4'($urandom),
                  ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom % mod_q),
                  r[ltr_pkg::NW-1:0], 1'b0, '0);
      end else if (pick < 9) begin
        send_item(ltr_pkg::CMD_COMPUTE, 4'($urandom), 31'($urandom),
                  (full_ok && $urandom_range(0, 5) == 0) ? r[ltr_pkg::NW-1:0]
                                                         : rand_n($urandom_range(0, max_bits)),
                  1'b0, '0);
      end else begin
        send_item(CMD_SPARE, 4'($urandom), 31'($urandom), r[ltr_pkg::NW-1:0], 1'b0, '0);
      end
    end
  endtask

  initial begin
    err_cnt = 0;
    cycle_cnt = 0;
    hold_req = 1'b0;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    mod_q = ltr_pkg::MODULUS_RESET;
    order_q = ltr_pkg::ORDER_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      coef_tab[i] = '0;
      init_tab[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++)
      send_item(DIRECTED[i].cmd, DIRECTED[i].idx, DIRECTED[i].val, DIRECTED[i].n,
                DIRECTED[i].fixed, DIRECTED[i].term);

    // modulus one zeroes everything, order zero acts as one
    set_regs(31'd1, 5'd0);
    send_item(ltr_pkg::CMD_COMPUTE, 4'd0, 31'd0, 63'd12345, 1'b1, 31'd0);
    // modulus zero acts as one, order above the depth acts as the depth
    set_regs(31'd0, 5'd31);
    send_item(ltr_pkg::CMD_COMPUTE, 4'd0, 31'd0, 63'd3, 1'b1, 31'd0);
    set_regs(31'h7fffffff, 5'd16);
    send_item(ltr_pkg::CMD_WR_INIT, 4'd1, 31'd1, 63'd0, 1'b0, '0);
    send_item(ltr_pkg::CMD_WR_COEF, 4'd14, 31'h7ffffffe, 63'd0, 1'b0, '0);
    send_item(ltr_pkg::CMD_COMPUTE, 4'd0, 31'd0, 63'd6, 1'b0, '0);
    random_phase(12, 2, 1'b0);

    // fibonacci-like setup with a long output hold-off
    set_regs(31'd1000000007, 5'd2);
    send_item(ltr_pkg::CMD_WR_COEF, 4'd0, 31'd1, 63'd0, 1'b0, '0);
    send_item(ltr_pkg::CMD_WR_COEF, 4'd1, 31'd1, 63'd0, 1'b0, '0);
    send_item(ltr_pkg::CMD_WR_INIT, 4'd0, 31'd0, 63'd0, 1'b0, '0);
    send_item(ltr_pkg::CMD_WR_INIT, 4'd1, 31'd1, 63'd0, 1'b0, '0);
    hold_req = 1'b1;
    random_phase(20, 16, 1'b1);

    for (int p = 0; p < 5; p++) begin
      set_regs((p == 0) ? 31'd2 :
               (p == 1) ? 31'($urandom_range(2, 100)) :
               31'($urandom_range(2, 32'h7fffffff)),
               5'($urandom_range(1, 4)));
      random_phase(10, 14, order_q <= 2);
    end

    s_axis_tvalid <= 1'b0;
    wait (term_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
